// File: hdl/matrix_multiply_transpose_assert.svh
// assertion macros shared by the matrix multiply checker
`ifndef MATRIX_MULTIPLY_TRANSPOSE_ASSERT_SVH
`define MATRIX_MULTIPLY_TRANSPOSE_ASSERT_SVH

// same-cycle implication, checked outside of an active disable condition
`define MMT_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("matrix multiply check failed");

// next-cycle implication, checked outside of an active disable condition
`define MMT_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("matrix multiply check failed");

`endif

// File: hdl/mmt_pkg.sv
// types, codes and constants of the matrix multiply engine
package mmt_pkg;

    // defaults of the top level parameters
    localparam int MAX_DIM_DEF     = 8;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed-point format
    localparam int FRAC_BITS = 16;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // input action codes
    localparam logic [1:0] ACT_WR_FIRST  = 2'd0;
    localparam logic [1:0] ACT_WR_SECOND = 2'd1;
    localparam logic [1:0] ACT_COMPUTE   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_RESULT_ROWS      = 3'd0;
    localparam logic [2:0] CFG_RESULT_COLS      = 3'd1;
    localparam logic [2:0] CFG_INNER_LENGTH     = 3'd2;
    localparam logic [2:0] CFG_TRANSPOSE_FIRST  = 3'd3;
    localparam logic [2:0] CFG_TRANSPOSE_SECOND = 3'd4;

    // configuration reset values
    localparam logic [3:0] DIM_RESET = 4'd8;

    // input item
    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         elem_row;
        logic [2:0]         elem_col;
        logic signed [31:0] element_value;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] result_value;
        logic               saturated;
        logic               last_of_run;
    } out_item_t;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_WR_FIRST,
        CMD_WR_SECOND,
        CMD_COMPUTE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } cmd_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [3:0] result_rows;
        logic [3:0] result_cols;
        logic [3:0] inner_length;
        logic       transpose_first;
        logic       transpose_second;
    } cfg_t;

endpackage

// File: hdl/mmt_front.sv
// front end: takes input transfers, drops dead items, builds commands
module mmt_front #(
    parameter int MAX_DIM = mmt_pkg::MAX_DIM_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mmt_pkg::in_item_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output mmt_pkg::cmd_t     cmd
);

    logic          cmd_valid_reg;
    mmt_pkg::cmd_t cmd_reg;
    mmt_pkg::cmd_t cmd_new;
    logic          keep;
    logic          in_range;

    // one-entry holding stage toward the queue
    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    // classify the incoming item
    always_comb begin
        in_range      = (int'(s_data.elem_row) < MAX_DIM) && (int'(s_data.elem_col) < MAX_DIM);
        cmd_new.row   = s_data.elem_row;
        cmd_new.col   = s_data.elem_col;
        cmd_new.value = s_data.element_value;
        cmd_new.kind  = mmt_pkg::CMD_COMPUTE;
        keep          = 1'b0;
        unique case (s_data.action)
            mmt_pkg::ACT_WR_FIRST: begin
                cmd_new.kind = mmt_pkg::CMD_WR_FIRST;
                keep         = in_range;
            end
            mmt_pkg::ACT_WR_SECOND: begin
                cmd_new.kind = mmt_pkg::CMD_WR_SECOND;
                keep         = in_range;
            end
            mmt_pkg::ACT_COMPUTE: begin
                cmd_new.kind = mmt_pkg::CMD_COMPUTE;
                keep         = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            if (cmd_valid_reg && cmd_ready) begin
                cmd_valid_reg <= 1'b0;
            end
            if (s_valid && s_ready && keep) begin
                cmd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && keep) begin
            cmd_reg <= cmd_new;
        end
    end

endmodule

// File: hdl/mmt_queue.sv
// short command queue between front and back
module mmt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  mmt_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output mmt_pkg::cmd_t rd_data
);

    localparam int PW = (mmt_pkg::QUEUE_DEPTH > 1) ? $clog2(mmt_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(mmt_pkg::QUEUE_DEPTH + 1);

    mmt_pkg::cmd_t slot_reg [mmt_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] count_reg;
    logic          push;
    logic          pop;

    assign wr_ready = (count_reg != CW'(mmt_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(mmt_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(mmt_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// File: hdl/mmt_back.sv
// back end: operand stores, multiply-accumulate sequencer, result register
module mmt_back #(
    parameter int MAX_DIM     = mmt_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = mmt_pkg::VALUE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mmt_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  mmt_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output mmt_pkg::out_item_t m_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    // operand stores
    logic signed [VALUE_WIDTH-1:0] first_mem  [DEPTH];
    logic signed [VALUE_WIDTH-1:0] second_mem [DEPTH];

    state_t             state_reg, state_next;
    logic [2:0]         r_reg, r_next;
    logic [2:0]         c_reg, c_next;
    logic [2:0]         k_reg, k_next;
    logic [2:0]         nr_m1_reg, nr_m1_next;
    logic [2:0]         nc_m1_reg, nc_m1_next;
    logic [2:0]         nk_m1_reg, nk_m1_next;
    logic               tf_reg, tf_next;
    logic               ts_reg, ts_next;
    logic               m_valid_reg, m_valid_next;
    mmt_pkg::out_item_t m_data_reg, m_data_next;

    logic                          issue;
    logic                          issue_first;
    logic                          issue_last;
    logic [AW-1:0]                 addr_first;
    logic [AW-1:0]                 addr_second;
    logic [AW-1:0]                 addr_wr;
    logic                          wr_first;
    logic                          wr_second;
    logic signed [VALUE_WIDTH-1:0] wr_value;

    logic                          rd_vld_reg, rd_first_reg, rd_last_reg;
    logic signed [VALUE_WIDTH-1:0] a_reg, b_reg;
    logic                          prod_vld_reg, prod_first_reg, prod_last_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic                          sum_rdy_reg;

    logic signed [ACC_W-1:0]       shifted;
    logic                          fits;
    logic signed [VALUE_WIDTH-1:0] sat_value;
    logic                          load_out;
    logic                          out_free;
    logic                          last_elem;

    // size register clamp to the range 1..MAX_DIM, kept as size minus one
    function automatic logic [2:0] dim_m1(input logic [3:0] v);
        logic [2:0] res;
        if (v == 4'd0) begin
            res = 3'd0;
        end else if (int'(v) > MAX_DIM) begin
            res = 3'(MAX_DIM - 1);
        end else begin
            res = 3'(v - 4'd1);
        end
        return res;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign last_elem = (r_reg == nr_m1_reg) && (c_reg == nc_m1_reg);
    assign cmd_ready = (state_reg == ST_IDLE);

    // store write decode
    assign wr_first  = cmd_valid && cmd_ready && (cmd.kind == mmt_pkg::CMD_WR_FIRST);
    assign wr_second = cmd_valid && cmd_ready && (cmd.kind == mmt_pkg::CMD_WR_SECOND);
    assign addr_wr   = AW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
    assign wr_value  = VALUE_WIDTH'(cmd.value);

    // operand addresses of the current step
    assign issue       = (state_reg == ST_RUN);
    assign issue_first = (k_reg == 3'd0);
    assign issue_last  = (k_reg == nk_m1_reg);
    assign addr_first  = tf_reg ? AW'(int'(k_reg) * MAX_DIM + int'(r_reg))
                                : AW'(int'(r_reg) * MAX_DIM + int'(k_reg));
    assign addr_second = ts_reg ? AW'(int'(c_reg) * MAX_DIM + int'(k_reg))
                                : AW'(int'(k_reg) * MAX_DIM + int'(c_reg));

    // stores: one write port, one registered read port each
    always_ff @(posedge aclk) begin
        if (wr_first) begin
            first_mem[addr_wr] <= wr_value;
        end
        a_reg <= first_mem[addr_first];
    end

    always_ff @(posedge aclk) begin
        if (wr_second) begin
            second_mem[addr_wr] <= wr_value;
        end
        b_reg <= second_mem[addr_second];
    end

    // multiply and accumulate pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
            sum_rdy_reg  <= 1'b0;
        end else begin
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;
            if (prod_vld_reg && prod_last_reg) begin
                sum_rdy_reg <= 1'b1;
            end else if (load_out) begin
                sum_rdy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_first_reg   <= issue_first;
        rd_last_reg    <= issue_last;
        prod_first_reg <= rd_first_reg;
        prod_last_reg  <= rd_last_reg;
        prod_reg       <= a_reg * b_reg;
        if (prod_vld_reg) begin
            if (prod_first_reg) begin
                acc_reg <= ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // floor back to the value format and saturate
    always_comb begin
        shifted = acc_reg >>> mmt_pkg::FRAC_BITS;
        fits    = (shifted[ACC_W-1:VALUE_WIDTH-1] == '0) || (shifted[ACC_W-1:VALUE_WIDTH-1] == '1);
        if (fits) begin
            sat_value = shifted[VALUE_WIDTH-1:0];
        end else if (shifted[ACC_W-1]) begin
            sat_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
    end

    // sequencer next state
    always_comb begin
        state_next   = state_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        k_next       = k_reg;
        nr_m1_next   = nr_m1_reg;
        nc_m1_next   = nc_m1_reg;
        nk_m1_next   = nk_m1_reg;
        tf_next      = tf_reg;
        ts_next      = ts_reg;
        m_data_next  = m_data_reg;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && (cmd.kind == mmt_pkg::CMD_COMPUTE)) begin
                    nr_m1_next = dim_m1(cfg.result_rows);
                    nc_m1_next = dim_m1(cfg.result_cols);
                    nk_m1_next = dim_m1(cfg.inner_length);
                    tf_next    = cfg.transpose_first;
                    ts_next    = cfg.transpose_second;
                    r_next     = 3'd0;
                    c_next     = 3'd0;
                    k_next     = 3'd0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issue_last) begin
                    k_next     = 3'd0;
                    state_next = ST_WAIT;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_WAIT: begin
                if (sum_rdy_reg && out_free) begin
                    load_out                 = 1'b1;
                    m_valid_next             = 1'b1;
                    m_data_next.out_row      = r_reg;
                    m_data_next.out_col      = c_reg;
                    m_data_next.result_value = 32'(sat_value);
                    m_data_next.saturated    = !fits;
                    m_data_next.last_of_run  = last_elem;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RUN;
                        if (c_reg == nc_m1_reg) begin
                            c_next = 3'd0;
                            r_next = r_reg + 3'd1;
                        end else begin
                            c_next = c_reg + 3'd1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        r_reg      <= r_next;
        c_reg      <= c_next;
        k_reg      <= k_next;
        nr_m1_reg  <= nr_m1_next;
        nc_m1_reg  <= nc_m1_next;
        nk_m1_reg  <= nk_m1_next;
        tf_reg     <= tf_next;
        ts_reg     <= ts_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hdl/matrix_multiply_transpose.sv
// Matrix multiply engine C = op(A) * op(B), top level.
// A command passes through the front holding register and the command queue to the sequencer;
// the sequencer takes commands only while idle, and a compute gives one result per element,
// each computed by the single multiply-accumulate unit and its read, multiply, add stages.
// The sequencer takes no new command until a compute run has given all its results.
// Reset: synchronous active-low aresetn clears control and restores 8, 8, 8, 0, 0.
module matrix_multiply_transpose #(
    parameter int MAX_DIM     = mmt_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = mmt_pkg::VALUE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [3:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  mmt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mmt_pkg::out_item_t m_data
);

    mmt_pkg::cfg_t cfg_reg;
    logic          f_valid;
    logic          f_ready;
    mmt_pkg::cmd_t f_cmd;
    logic          q_valid;
    logic          q_ready;
    mmt_pkg::cmd_t q_cmd;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.result_rows      <= mmt_pkg::DIM_RESET;
            cfg_reg.result_cols      <= mmt_pkg::DIM_RESET;
            cfg_reg.inner_length     <= mmt_pkg::DIM_RESET;
            cfg_reg.transpose_first  <= 1'b0;
            cfg_reg.transpose_second <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                mmt_pkg::CFG_RESULT_ROWS:      cfg_reg.result_rows      <= cfg_wdata;
                mmt_pkg::CFG_RESULT_COLS:      cfg_reg.result_cols      <= cfg_wdata;
                mmt_pkg::CFG_INNER_LENGTH:     cfg_reg.inner_length     <= cfg_wdata;
                mmt_pkg::CFG_TRANSPOSE_FIRST:  cfg_reg.transpose_first  <= cfg_wdata[0];
                mmt_pkg::CFG_TRANSPOSE_SECOND: cfg_reg.transpose_second <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // input classification
    mmt_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // command queue
    mmt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_cmd)
    );

    // stores and multiply-accumulate
    mmt_back #(
        .MAX_DIM     (MAX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hdl/mmt_checker.sv
// port-level checker for the matrix multiply engine, bound to the top level
`include "matrix_multiply_transpose_assert.svh"

module mmt_checker #(
    parameter int MAX_DIM     = mmt_pkg::MAX_DIM_DEF,
    parameter int VALUE_WIDTH = mmt_pkg::VALUE_WIDTH_DEF
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input mmt_pkg::out_item_t m_data
);

    localparam longint VMAX_L = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
    localparam logic [31:0] VMAX = 32'(VMAX_L);
    localparam logic [31:0] VMIN = 32'(-VMAX_L - 64'sd1);

    logic in_range;

    // a result inside the value range has its upper bits all equal to the sign
    assign in_range = ($signed(m_data.result_value) <= $signed(VMAX))
                   && ($signed(m_data.result_value) >= $signed(VMIN));

    // held result keeps its payload until transfer
    `MMT_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // no result right after reset
    `MMT_ASSERT_NEXT(a_reset_quiet, aclk, 1'b0, !aresetn, !m_valid)

    // a clipped result sits on a range limit
    `MMT_ASSERT_NOW(a_sat_limit, aclk, !aresetn, m_valid && m_data.saturated,
                    (m_data.result_value == VMAX) || (m_data.result_value == VMIN))

    // an unclipped result fits the value range and its indexes fit the matrix
    `MMT_ASSERT_NOW(a_result_range, aclk, !aresetn, m_valid && !m_data.saturated,
                    in_range && (int'(m_data.out_row) < MAX_DIM) && (int'(m_data.out_col) < MAX_DIM))

endmodule

bind matrix_multiply_transpose mmt_checker #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mmt_checker (.*);

// File: test/testbench.sv
// self-checking testbench for the matrix multiply engine with operand transpose
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM        = mmt_pkg::MAX_DIM_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
    localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_addr  = '0;
    logic [3:0]         cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    mmt_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    mmt_pkg::out_item_t m_data;

    // operand stores and register copies as the engine should hold them
    logic signed [31:0] first_store  [MAX_DIM*MAX_DIM];
    logic signed [31:0] second_store [MAX_DIM*MAX_DIM];
    logic [3:0] cfg_rows  = mmt_pkg::DIM_RESET;
    logic [3:0] cfg_cols  = mmt_pkg::DIM_RESET;
    logic [3:0] cfg_inner = mmt_pkg::DIM_RESET;
    logic       cfg_ta    = 1'b0;
    logic       cfg_tb    = 1'b0;

    // stimulus bookkeeping: which store entries have been written so far
    bit first_set  [MAX_DIM*MAX_DIM];
    bit second_set [MAX_DIM*MAX_DIM];

    mmt_pkg::in_item_t  cmd_backlog [$];
    mmt_pkg::out_item_t c_due [$];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    bit  idling = 1'b1;
    bit  long_hold_pending = 1'b0;

    matrix_multiply_transpose dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // effective size of a dimension register
    function automatic int dim_of(logic [3:0] v);
        if (v == 4'd0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // store update or full C = op(A) * op(B) run for one accepted transfer
    function automatic void run_gemm_item(mmt_pkg::in_item_t it);
        int nr, nc, nk, r, c, k;
        logic signed [31:0] a, b;
        logic signed [71:0] prod, acc, scaled;
        mmt_pkg::out_item_t el;
        nr = dim_of(cfg_rows);
        nc = dim_of(cfg_cols);
        nk = dim_of(cfg_inner);
        case (it.action)
            mmt_pkg::ACT_WR_FIRST:
                first_store[it.elem_row*MAX_DIM + it.elem_col] = it.element_value;
            mmt_pkg::ACT_WR_SECOND:
                second_store[it.elem_row*MAX_DIM + it.elem_col] = it.element_value;
            mmt_pkg::ACT_COMPUTE: begin
                for (r = 0; r < nr; r++) begin
                    for (c = 0; c < nc; c++) begin
                        acc = '0;
                        for (k = 0; k < nk; k++) begin
                            a = cfg_ta ? first_store[k*MAX_DIM + r] : first_store[r*MAX_DIM + k];
                            b = cfg_tb ? second_store[c*MAX_DIM + k] : second_store[k*MAX_DIM + c];
                            prod = a * b;
                            acc = acc + prod;
                        end
                        // floor back to Q16.16, then clip
                        scaled = acc >>> mmt_pkg::FRAC_BITS;
                        el.saturated = 1'b0;
                        if (scaled > Q_MAX) begin
                            scaled = Q_MAX;
                            el.saturated = 1'b1;
                        end
                        if (scaled < Q_MIN) begin
                            scaled = Q_MIN;
                            el.saturated = 1'b1;
                        end
                        el.out_row = 3'(r);
                        el.out_col = 3'(c);
                        el.result_value = scaled[31:0];
                        el.last_of_run = (r == nr - 1) && (c == nc - 1);
                        c_due.push_back(el);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // input driver, fed from the backlog
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) run_gemm_item(s_data);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    s_valid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    s_data <= cmd_backlog.pop_front();
                    s_valid <= 1'b1;
                    if (idling && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        mmt_pkg::out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (c_due.size() == 0) begin
                    $error("result transfer with nothing due: row %0d col %0d value %h",
                           m_data.out_row, m_data.out_col, m_data.result_value);
                    mismatch_count++;
                end else begin
                    want = c_due.pop_front();
                    if (m_data.out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d", want.out_row, m_data.out_row);
                        mismatch_count++;
                    end
                    if (m_data.out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d", want.out_col, m_data.out_col);
                        mismatch_count++;
                    end
                    if (m_data.result_value !== want.result_value) begin
                        $error("result_value: expected %h, got %h",
                               want.result_value, m_data.result_value);
                        mismatch_count++;
                    end
                    if (m_data.saturated !== want.saturated) begin
                        $error("saturated: expected %0b, got %0b", want.saturated, m_data.saturated);
                        mismatch_count++;
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, m_data.last_of_run);
                        mismatch_count++;
                    end
                end
            end
            // long hold first, then short random stalls
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (idling && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("matrix_multiply_transpose test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // element value mix: extremes, small, mid-range and full-range
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            5, 6: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
            7, 8: return 32'($urandom_range(0, 32'h1FF_FFFF)) - 32'h100_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_item(logic [1:0] act, logic [2:0] row, logic [2:0] col,
                                      logic [31:0] value);
        mmt_pkg::in_item_t it;
        it.action = act;
        it.elem_row = row;
        it.elem_col = col;
        it.element_value = value;
        cmd_backlog.push_back(it);
        if (act == mmt_pkg::ACT_WR_FIRST) first_set[row*MAX_DIM + col] = 1'b1;
        if (act == mmt_pkg::ACT_WR_SECOND) second_set[row*MAX_DIM + col] = 1'b1;
        items_sent++;
    endfunction

    // write every operand entry the current shape reads but nobody wrote yet
    function automatic void fill_operands();
        int nr, nc, nk, r, c, k, idx;
        nr = dim_of(cfg_rows);
        nc = dim_of(cfg_cols);
        nk = dim_of(cfg_inner);
        for (r = 0; r < nr; r++) begin
            for (k = 0; k < nk; k++) begin
                idx = cfg_ta ? k*MAX_DIM + r : r*MAX_DIM + k;
                if (!first_set[idx])
                    push_item(mmt_pkg::ACT_WR_FIRST, 3'(idx / MAX_DIM), 3'(idx % MAX_DIM),
                              pick_value());
            end
        end
        for (k = 0; k < nk; k++) begin
            for (c = 0; c < nc; c++) begin
                idx = cfg_tb ? c*MAX_DIM + k : k*MAX_DIM + c;
                if (!second_set[idx])
                    push_item(mmt_pkg::ACT_WR_SECOND, 3'(idx / MAX_DIM), 3'(idx % MAX_DIM),
                              pick_value());
            end
        end
    endfunction

    // random writes, computes and unused actions, closed by a compute
    function automatic void random_traffic(int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 36)
                push_item(mmt_pkg::ACT_WR_FIRST, 3'($urandom), 3'($urandom), pick_value());
            else if (roll < 72)
                push_item(mmt_pkg::ACT_WR_SECOND, 3'($urandom), 3'($urandom), pick_value());
            else if (roll < 92)
                push_item(mmt_pkg::ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom());
            else
                push_item(ACT_UNUSED, 3'($urandom), 3'($urandom), $urandom());
        end
        push_item(mmt_pkg::ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom());
    endfunction

    function automatic logic [3:0] rand_dim();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 15) return 4'($urandom_range(1, 4));
        if (roll < 18) return 4'($urandom_range(5, 8));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [3:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            mmt_pkg::CFG_RESULT_ROWS:      cfg_rows = val;
            mmt_pkg::CFG_RESULT_COLS:      cfg_cols = val;
            mmt_pkg::CFG_INNER_LENGTH:     cfg_inner = val;
            mmt_pkg::CFG_TRANSPOSE_FIRST:  cfg_ta = val[0];
            mmt_pkg::CFG_TRANSPOSE_SECOND: cfg_tb = val[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // transpose flags carry random upper bits, which the engine must ignore
    task automatic set_shape(logic [3:0] rows, logic [3:0] cols, logic [3:0] inner,
                             logic ta, logic tb);
        write_reg(mmt_pkg::CFG_RESULT_ROWS, rows);
        write_reg(mmt_pkg::CFG_RESULT_COLS, cols);
        write_reg(mmt_pkg::CFG_INNER_LENGTH, inner);
        write_reg(mmt_pkg::CFG_TRANSPOSE_FIRST, {3'($urandom), ta});
        write_reg(mmt_pkg::CFG_TRANSPOSE_SECOND, {3'($urandom), tb});
    endtask

    // wait until every command went through and every element came back
    task automatic drain();
        do @(posedge aclk);
        while (cmd_backlog.size() != 0 || s_valid || c_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // stimulus sequence
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset shape 8x8x8: extremes in the corners, unused action, full compute
        push_item(mmt_pkg::ACT_WR_FIRST, 3'd0, 3'd0, 32'h7FFF_FFFF);
        push_item(mmt_pkg::ACT_WR_FIRST, 3'd7, 3'd7, 32'h8000_0000);
        push_item(mmt_pkg::ACT_WR_FIRST, 3'd0, 3'd7, 32'h0000_0000);
        push_item(mmt_pkg::ACT_WR_SECOND, 3'd0, 3'd0, 32'h7FFF_FFFF);
        push_item(mmt_pkg::ACT_WR_SECOND, 3'd7, 3'd7, 32'h8000_0000);
        push_item(mmt_pkg::ACT_WR_SECOND, 3'd7, 3'd0, 32'hFFFF_0000);
        push_item(ACT_UNUSED, 3'd5, 3'd2, 32'h1234_5678);
        fill_operands();
        push_item(mmt_pkg::ACT_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);

        // 1x1x1: floor of a negative product, both saturation directions, unity
        drain();
        set_shape(4'd1, 4'd1, 4'd1, 1'b0, 1'b0);
        push_item(mmt_pkg::ACT_WR_FIRST, 3'd0, 3'd0, 32'hFFFF_FFFF);
        push_item(mmt_pkg::ACT_WR_SECOND, 3'd0, 3'd0, 32'h0000_0001);
        push_item(mmt_pkg::ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        push_item(mmt_pkg::ACT_WR_FIRST, 3'd0, 3'd0, 32'h8000_0000);
        push_item(mmt_pkg::ACT_WR_SECOND, 3'd0, 3'd0, 32'h8000_0000);
        push_item(mmt_pkg::ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        push_item(mmt_pkg::ACT_WR_SECOND, 3'd0, 3'd0, 32'h7FFF_FFFF);
        push_item(mmt_pkg::ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        push_item(mmt_pkg::ACT_WR_FIRST, 3'd0, 3'd0, 32'h0001_0000);
        push_item(mmt_pkg::ACT_WR_SECOND, 3'd0, 3'd0, 32'hFFFF_0000);
        push_item(mmt_pkg::ACT_COMPUTE, 3'd0, 3'd0, 32'h0);

        // out-of-range sizes: zero acts as one, above the maximum as the maximum
        drain();
        set_shape(4'd0, 4'd15, 4'd0, 1'b1, 1'b1);
        push_item(mmt_pkg::ACT_COMPUTE, 3'd1, 3'd6, 32'h0);
        drain();
        set_shape(4'd15, 4'd0, 4'd15, 1'b1, 1'b0);
        push_item(mmt_pkg::ACT_COMPUTE, 3'd0, 3'd0, 32'h0);
        drain();
        set_shape(4'd8, 4'd8, 4'd8, 1'b1, 1'b1);
        push_item(mmt_pkg::ACT_COMPUTE, 3'd0, 3'd0, 32'h0);

        // receiver holds off while the sender keeps offering, to back up the input
        drain();
        idling = 1'b0;
        set_shape(4'd2, 4'd3, 4'd4, 1'b0, 1'b1);
        long_hold_pending = 1'b1;
        repeat (4) begin
            push_item(mmt_pkg::ACT_COMPUTE, 3'($urandom), 3'($urandom), $urandom());
            push_item(mmt_pkg::ACT_WR_FIRST, 3'($urandom), 3'($urandom), pick_value());
            push_item(mmt_pkg::ACT_WR_SECOND, 3'($urandom), 3'($urandom), pick_value());
        end
        push_item(mmt_pkg::ACT_COMPUTE, 3'd0, 3'd0, 32'h0);

        // random phases, each with its own shape
        while (items_sent < 270) begin
            drain();
            idling = ($urandom_range(0, 9) < 7);
            set_shape(rand_dim(), rand_dim(), rand_dim(), 1'($urandom), 1'($urandom));
            fill_operands();
            random_traffic($urandom_range(10, 30));
        end

        // closing phase without idling
        drain();
        idling = 1'b0;
        set_shape(rand_dim(), rand_dim(), rand_dim(), 1'($urandom), 1'($urandom));
        fill_operands();
        random_traffic(40);
        drain();

        if (mismatch_count == 0 && c_due.size() == 0) begin
            $display("matrix_multiply_transpose test passed");
        end else begin
            $display("matrix_multiply_transpose test failed");
        end
        $finish;
    end

endmodule
